// ===== sv/tgso_pkg.sv =====
package tgso_pkg;

	// grid limits
	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;

	localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ADDR_W  = COL_W + ROW_W;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int WID_W   = $clog2(MAX_COLUMNS + 1);
	localparam int HGT_W   = $clog2(MAX_ROWS + 1);
	localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;

	// tile edge positions in whole world units, then the signed Q16.8 compare width
	localparam int WU_W  = $clog2(MAX_DIM + 1) + 8;
	localparam int CMP_W = (WU_W + 9 > 24) ? WU_W + 9 : 24;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'((64 > MAX_COLUMNS) ? MAX_COLUMNS : 64);
	localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'((64 > MAX_ROWS) ? MAX_ROWS : 64);
	localparam logic [7:0]       SIZE_RST   = 8'd16;

	localparam logic signed [15:0] EMPTY_TILE = -16'sd1;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE  = 2'd3
	} action_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SIZE   = 2'd2,
		REG_NONE   = 2'd3
	} reg_e;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DRAIN
	} state_e;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] cell_x;
		logic signed [15:0] cell_y;
		logic signed [15:0] tile_index;
		logic               solid_flag;
		logic signed [23:0] rect_min_x;
		logic signed [23:0] rect_min_y;
		logic signed [23:0] rect_max_x;
		logic signed [23:0] rect_max_y;
	} in_t;

	typedef struct packed {
		logic               accepted;
		logic signed [15:0] read_tile;
		logic               read_solid;
		logic               overlap_hit;
	} out_t;

	typedef struct packed {
		logic               solid;
		logic signed [15:0] tile;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	localparam cell_t CELL_EMPTY = '{solid: 1'b0, tile: EMPTY_TILE};

	typedef struct packed {
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
		logic [7:0]       size;
		logic             clear;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		cell_t             wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== sv/tgso_ram.sv =====
module tgso_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/tgso_cfg.sv =====
module tgso_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tgso_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tgso_pkg::CFG_DATA_W-1:0]     cfg_data,
	output tgso_pkg::cfg_t                      cfg
);

	logic [tgso_pkg::WID_W-1:0] width_q;
	logic [tgso_pkg::HGT_W-1:0] height_q;
	logic [7:0]                 size_q;
	logic [6:0]                 dim_val;
	logic                       wr_width;
	logic                       wr_height;
	logic                       wr_size;

	assign cfg_ready = 1'b1;
	assign dim_val   = cfg_data[6:0];

	assign wr_width  = cfg_valid && (cfg_index == tgso_pkg::REG_WIDTH);
	assign wr_height = cfg_valid && (cfg_index == tgso_pkg::REG_HEIGHT);
	// zero size is dropped and leaves the store alone
	assign wr_size   = cfg_valid && (cfg_index == tgso_pkg::REG_SIZE) && (cfg_data != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tgso_pkg::WIDTH_RST;
			height_q <= tgso_pkg::HEIGHT_RST;
			size_q   <= tgso_pkg::SIZE_RST;
		end else begin
			if (wr_width) begin
				width_q <= (32'(dim_val) > tgso_pkg::MAX_COLUMNS) ?
					tgso_pkg::WID_W'(tgso_pkg::MAX_COLUMNS) : tgso_pkg::WID_W'(dim_val);
			end
			if (wr_height) begin
				height_q <= (32'(dim_val) > tgso_pkg::MAX_ROWS) ?
					tgso_pkg::HGT_W'(tgso_pkg::MAX_ROWS) : tgso_pkg::HGT_W'(dim_val);
			end
			if (wr_size) begin
				size_q <= cfg_data[7:0];
			end
		end
	end

	always_comb begin
		cfg.width  = width_q;
		cfg.height = height_q;
		cfg.size   = size_q;
		cfg.clear  = wr_width || wr_height || wr_size;
	end

endmodule

// ===== sv/tgso_ctrl.sv =====
module tgso_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tgso_pkg::cfg_t        cfg,
	input  logic                  start,
	output logic                  busy,
	input  tgso_pkg::in_t         cmd,
	output logic                  done,
	output tgso_pkg::out_t        result,
	output tgso_pkg::mem_req_t    mem_req,
	input  tgso_pkg::cell_t       mem_rdata
);

	localparam int COL_W  = tgso_pkg::COL_W;
	localparam int ROW_W  = tgso_pkg::ROW_W;
	localparam int ADDR_W = tgso_pkg::ADDR_W;
	localparam int WU_W   = tgso_pkg::WU_W;
	localparam int CMP_W  = tgso_pkg::CMP_W;

	// whole world units to signed Q16.8
	function automatic logic signed [CMP_W-1:0] to_q(input logic [WU_W-1:0] w);
		return $signed({{(CMP_W-WU_W-8){1'b0}}, w, 8'b0});
	endfunction

	tgso_pkg::state_e state_q, state_d;

	logic [ADDR_W-1:0]       clr_q;
	logic [COL_W-1:0]        x_q;
	logic [ROW_W-1:0]        y_q;
	logic [WU_W-1:0]         left_q;
	logic [WU_W-1:0]         top_q;
	logic signed [CMP_W-1:0] minx_q, miny_q, maxx_q, maxy_q;
	logic                    vld_s1, xo_s1, yo_s1;
	logic                    done_q;
	tgso_pkg::out_t          res_q;

	logic                    done_d;
	tgso_pkg::out_t          res_d;
	logic                    start_ok;
	logic                    in_grid;
	logic [ADDR_W-1:0]       cell_addr;
	logic                    grid_empty;
	logic                    last_x, last_y;
	logic                    hit_now;
	logic                    issue;
	logic [WU_W-1:0]         right, bottom;
	logic                    xo, yo;

	assign start_ok  = start && (state_q == tgso_pkg::ST_IDLE) && !cfg.clear;
	assign busy      = (state_q != tgso_pkg::ST_IDLE) || cfg.clear;

	assign in_grid   = !cmd.cell_x[15] && !cmd.cell_y[15] &&
		(cmd.cell_x[14:0] < 15'(cfg.width)) && (cmd.cell_y[14:0] < 15'(cfg.height));
	assign cell_addr = {cmd.cell_y[ROW_W-1:0], cmd.cell_x[COL_W-1:0]};
	assign grid_empty = (cfg.width == '0) || (cfg.height == '0);

	assign last_x  = (x_q == COL_W'(cfg.width - 1'b1));
	assign last_y  = (y_q == ROW_W'(cfg.height - 1'b1));
	assign issue   = (state_q == tgso_pkg::ST_SCAN);
	assign hit_now = vld_s1 && mem_rdata.solid && xo_s1 && yo_s1;

	assign right  = left_q + WU_W'(cfg.size);
	assign bottom = top_q + WU_W'(cfg.size);
	assign xo     = (minx_q < to_q(right)) && (maxx_q > to_q(left_q));
	assign yo     = (miny_q < to_q(bottom)) && (maxy_q > to_q(top_q));

	// next state
	always_comb begin
		state_d = state_q;
		if (cfg.clear) begin
			state_d = tgso_pkg::ST_CLEAR;
		end else begin
			case (state_q)
				tgso_pkg::ST_CLEAR: begin
					if (clr_q == '1) state_d = tgso_pkg::ST_IDLE;
				end
				tgso_pkg::ST_IDLE: begin
					if (start_ok) begin
						if (cmd.action == tgso_pkg::ACT_READ && in_grid) begin
							state_d = tgso_pkg::ST_READ;
						end else if (cmd.action == tgso_pkg::ACT_QUERY && !grid_empty) begin
							state_d = tgso_pkg::ST_SCAN;
						end
					end
				end
				tgso_pkg::ST_READ: state_d = tgso_pkg::ST_IDLE;
				tgso_pkg::ST_SCAN: begin
					if (hit_now) begin
						state_d = tgso_pkg::ST_IDLE;
					end else if (last_x && last_y) begin
						state_d = tgso_pkg::ST_DRAIN;
					end
				end
				tgso_pkg::ST_DRAIN: state_d = tgso_pkg::ST_IDLE;
				default: state_d = tgso_pkg::ST_IDLE;
			endcase
		end
	end

	// memory port and result
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = clr_q;
		mem_req.wdata = tgso_pkg::CELL_EMPTY;
		mem_req.raddr = {y_q, x_q};
		done_d        = 1'b0;
		res_d         = '0;
		case (state_q)
			tgso_pkg::ST_CLEAR: begin
				mem_req.we = 1'b1;
			end
			tgso_pkg::ST_IDLE: begin
				if (start_ok) begin
					case (tgso_pkg::action_e'(cmd.action))
						tgso_pkg::ACT_WRITE: begin
							mem_req.we          = in_grid;
							mem_req.waddr       = cell_addr;
							mem_req.wdata.solid = cmd.solid_flag;
							mem_req.wdata.tile  = cmd.tile_index;
							done_d              = 1'b1;
							res_d.accepted      = in_grid;
						end
						tgso_pkg::ACT_READ: begin
							mem_req.raddr = cell_addr;
							if (!in_grid) begin
								done_d          = 1'b1;
								res_d.read_tile = tgso_pkg::EMPTY_TILE;
							end
						end
						tgso_pkg::ACT_QUERY: begin
							done_d = grid_empty;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			tgso_pkg::ST_READ: begin
				done_d           = 1'b1;
				res_d.accepted   = 1'b1;
				res_d.read_tile  = mem_rdata.tile;
				res_d.read_solid = mem_rdata.solid;
			end
			tgso_pkg::ST_SCAN: begin
				done_d            = hit_now;
				res_d.overlap_hit = hit_now;
			end
			tgso_pkg::ST_DRAIN: begin
				done_d            = 1'b1;
				res_d.overlap_hit = hit_now;
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgso_pkg::ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			vld_s1  <= issue;
			if (cfg.clear) begin
				clr_q <= '0;
			end else if (state_q == tgso_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// scan walk: running tile edges replace the multiply
	always_ff @(posedge clk) begin
		res_q <= res_d;
		xo_s1 <= xo;
		yo_s1 <= yo;
		if (start_ok && cmd.action == tgso_pkg::ACT_QUERY) begin
			x_q    <= '0;
			y_q    <= '0;
			left_q <= '0;
			top_q  <= '0;
			minx_q <= CMP_W'(cmd.rect_min_x);
			miny_q <= CMP_W'(cmd.rect_min_y);
			maxx_q <= CMP_W'(cmd.rect_max_x);
			maxy_q <= CMP_W'(cmd.rect_max_y);
		end else if (issue) begin
			if (last_x) begin
				x_q    <= '0;
				left_q <= '0;
				if (!last_y) begin
					y_q   <= y_q + 1'b1;
					top_q <= bottom;
				end
			end else begin
				x_q    <= x_q + 1'b1;
				left_q <= right;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== sv/tile_grid_solid_overlap.sv =====
// Tile grid with cell write/read and a solid-tile box overlap query.
// Command channel: cmd is transferred at a rising edge with start high and
// busy low. Each command gives exactly one result on result, marked by a
// one-cycle done strobe; the receiver cannot hold it off.
// Write: result one cycle after the transfer. Read: inside the grid the
// result passes the RAM read and done registers; outside, the cycle after.
// Query: one cell per cycle in raster order, ending at the first solid hit;
// a store clear can drop it with no result. A new command may be transferred
// in the cycle done is shown. The cell store is a single-port-write,
// registered-read RAM; the scan is bound by its one read per cycle.
// Configuration: cfg_valid/cfg_ready write port, always ready, index 0 width,
// 1 height, 2 tile size. Any width or height write, and a nonzero tile size
// write, clears the store; a zero tile size is dropped.
// Reset and every such clear run a pass writing each of the 4096 cells to
// empty (tile -1, not solid); busy stays high throughout and no command is
// taken, while configuration writes are still taken.
module tile_grid_solid_overlap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  tgso_pkg::in_t                       cmd,
	output logic                                done,
	output tgso_pkg::out_t                      result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tgso_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tgso_pkg::CFG_DATA_W-1:0]     cfg_data
);

	tgso_pkg::cfg_t     cfg;
	tgso_pkg::mem_req_t mem_req;
	tgso_pkg::cell_t    mem_rdata;

	tgso_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tgso_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	tgso_ram #(
		.WIDTH (tgso_pkg::CELL_W),
		.DEPTH (tgso_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule
